### rtl/i4gd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i4gd_pkg: shared types and helpers for the int4 group dequantiser
// Payload structs, lane count and half to single widening.
// ----------------------------------------------------------------------------
package i4gd_pkg;

	localparam int unsigned Lanes   = 8;
	localparam int unsigned NumOut  = 8;

	localparam logic [31:0] F32ExpMask  = 32'h7F80_0000;
	localparam logic [31:0] F32Quiet    = 32'h0040_0000;
	localparam logic [31:0] F32CanonNan = 32'h7FC0_0000;

	typedef struct packed {
		logic [15:0] group_scale;
		logic [31:0] packed_codes;
	} in_t;

	typedef struct packed {
		logic [31:0] value_7;
		logic [31:0] value_6;
		logic [31:0] value_5;
		logic [31:0] value_4;
		logic [31:0] value_3;
		logic [31:0] value_2;
		logic [31:0] value_1;
		logic [31:0] value_0;
	} out_t;

	// widen an IEEE half to single; subnormals normalised by leading-zero count
	function automatic logic [31:0] widen_half(input logic [15:0] h);
		logic [31:0] sgn;
		logic [4:0]  ex;
		logic [9:0]  fr;
		logic [3:0]  lz;
		logic [9:0]  nf;
		logic [7:0]  e;
		sgn = {h[15], 31'd0};
		ex  = h[14:10];
		fr  = h[9:0];
		lz  = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (fr[i])
				lz = 4'(9 - i);
		end
		nf = 10'(fr << (lz + 4'd1));
		e  = 8'd113 - 8'(lz) - 8'd1;
		if (ex == 5'd0) begin
			if (fr == 10'd0)
				widen_half = sgn;
			else
				widen_half = sgn | {1'b0, e, nf, 13'd0};
		end else if (ex == 5'h1F) begin
			widen_half = sgn | F32ExpMask | {9'd0, fr, 13'd0};
		end else begin
			widen_half = sgn | {1'b0, 8'({3'd0, ex} + 8'd112), fr, 13'd0};
		end
	endfunction

endpackage
`default_nettype wire

### rtl/i4gd_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i4gd_lane: one dequantisation lane
// Multiplies a widened scale by (code - 8); exact, no rounding.
// ----------------------------------------------------------------------------
module i4gd_lane (
	input  wire logic [31:0] scale,
	input  wire logic [3:0]  code,
	output logic      [31:0] value
);
	logic        neg;
	logic [3:0]  mag;
	logic [31:0] psign;
	logic [7:0]  ex;
	logic [22:0] fr;
	logic [27:0] p;
	logic [1:0]  sh;
	logic [23:0] pn;

	always_comb begin
		neg   = ~code[3];
		mag   = neg ? 4'(4'd8 - code) : 4'(code - 4'd8);
		psign = {scale[31] ^ neg, 31'd0};
		ex    = scale[30:23];
		fr    = scale[22:0];
		p     = {4'd0, 1'b1, fr} * {24'd0, mag};
		// product below 2^27, so at most three normalising shifts
		if (p[26])      sh = 2'd3;
		else if (p[25]) sh = 2'd2;
		else if (p[24]) sh = 2'd1;
		else            sh = 2'd0;
		pn = 24'(p >> sh);
		if (ex == 8'hFF) begin
			if (fr != 23'd0)
				value = scale | i4gd_pkg::F32Quiet;
			else if (mag == 4'd0)
				value = i4gd_pkg::F32CanonNan;
			else
				value = psign | i4gd_pkg::F32ExpMask;
		end else if (ex == 8'd0 || mag == 4'd0) begin
			value = psign;
		end else begin
			value = psign | {1'b0, 8'(ex + {6'd0, sh}), pn[22:0]};
		end
	end
endmodule
`default_nettype wire

### rtl/int4_group_dequantizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// int4_group_dequantizer_unit: int4 codes times fp16 group scale to fp32
// Widen the scale into stage 1, eight lanes into the output register. One
// request per cycle; both stages advance when the output register is empty or
// being taken, stage 1 also when empty. Reset empties both stages.
// ----------------------------------------------------------------------------
module int4_group_dequantizer_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire i4gd_pkg::in_t   in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output i4gd_pkg::out_t       out_data
);
	logic        v_s1;
	logic [31:0] scale_s1;
	logic [31:0] codes_s1;
	logic        adv;
	logic [31:0] lane_val [i4gd_pkg::Lanes];
	logic [31:0] merged   [i4gd_pkg::NumOut];

	assign adv      = ~out_valid | out_ready;
	assign in_ready = adv | ~v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			scale_s1 <= i4gd_pkg::widen_half(in_data.group_scale);
			codes_s1 <= in_data.packed_codes;
		end
	end

	for (genvar g = 0; g < i4gd_pkg::Lanes; g++) begin : g_lane
		i4gd_lane u_lane (
			.scale (scale_s1),
			.code  (codes_s1[4*g +: 4]),
			.value (lane_val[g])
		);
	end

	// merge lanes; unused outputs read zero
	always_comb begin
		for (int i = 0; i < i4gd_pkg::NumOut; i++)
			merged[i] = (i < i4gd_pkg::Lanes) ? lane_val[i] : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			out_data <= {merged[7], merged[6], merged[5], merged[4],
				merged[3], merged[2], merged[1], merged[0]};
		end
	end

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv) |=> out_valid)
		else $error("stage 1 request lost on advance");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid && !out_ready) |-> !in_ready)
		else $error("request accepted with pipeline full");
endmodule
`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: request-level check of the int4 group dequantiser
// Drives packed codes with fp16 scales, predicts the eight fp32 lanes from an
// independent model of scale widening and exact product, and compares results.
// ----------------------------------------------------------------------------
module testbench;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	i4gd_pkg::in_t  in_data = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	i4gd_pkg::out_t out_data;

	i4gd_pkg::out_t lanes_due[$];
	int   errors = 0;
	int   send_idle = 0;
	int   recv_stall = 0;
	int   hold_off = 0;
	int   cycles = 0;

	int4_group_dequantizer_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [31:0] s;
		logic [4:0]  ex;
		logic [10:0] fr;
		logic [7:0]  e;
		s  = {h[15], 31'd0};
		ex = h[14:10];
		fr = {1'b0, h[9:0]};
		if (ex == 5'd0) begin
			if (fr == 11'd0)
				return s;
			e = 8'd113;
			while (!fr[10]) begin
				fr = fr << 1;
				e  = e - 8'd1;
			end
			return s | {1'b0, e, fr[9:0], 13'd0};
		end
		if (ex == 5'h1F)
			return s | 32'h7F80_0000 | {9'd0, fr[9:0], 13'd0};
		return s | {1'b0, 8'(ex) + 8'd112, fr[9:0], 13'd0};
	endfunction

	function automatic logic [31:0] lane_value(input logic [31:0] s, input logic [3:0] code);
		logic        neg;
		logic [3:0]  mag;
		logic [31:0] sgn;
		logic [7:0]  ex;
		logic [31:0] p;
		logic [7:0]  sh;
		neg = code < 4'd8;
		mag = neg ? 4'd8 - code : code - 4'd8;
		sgn = {s[31] ^ neg, 31'd0};
		ex  = s[30:23];
		if (ex == 8'hFF) begin
			if (s[22:0] != 23'd0)
				return s | 32'h0040_0000;
			if (mag == 4'd0)
				return 32'h7FC0_0000;
			return sgn | 32'h7F80_0000;
		end
		if (ex == 8'd0 || mag == 4'd0)
			return sgn;
		p  = {8'd0, 1'b1, s[22:0]} * mag;
		sh = 8'd0;
		while (p >= 32'h0100_0000) begin
			p  = p >> 1;
			sh = sh + 8'd1;
		end
		return sgn | {1'b0, ex + sh, p[22:0]};
	endfunction

	function automatic i4gd_pkg::out_t dequantise(input i4gd_pkg::in_t req);
		logic [31:0] s;
		logic [31:0] v [8];
		s = half_to_single(req.group_scale);
		for (int i = 0; i < 8; i++)
			v[i] = (i < i4gd_pkg::Lanes) ? lane_value(s, req.packed_codes[4*i +: 4]) : 32'd0;
		return '{v[7], v[6], v[5], v[4], v[3], v[2], v[1], v[0]};
	endfunction

	task automatic send_request(input logic [31:0] codes, input logic [15:0] scale);
		int gap;
		gap = ($urandom_range(99) < send_idle) ? $urandom_range(4, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= '{group_scale: scale, packed_codes: codes};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		lanes_due.push_back(dequantise('{group_scale: scale, packed_codes: codes}));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (lanes_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// receiver: random stall, or a counted hold-off when asked
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off  <= hold_off - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		i4gd_pkg::out_t e;
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Mismatches found");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (lanes_due.size() == 0) begin
				$error("result with no request outstanding: %h", out_data);
				errors++;
			end else begin
				e = lanes_due.pop_front();
				for (int i = 0; i < 8; i++)
					if (out_data[32*i +: 32] !== e[32*i +: 32]) begin
						$error("value_%0d expected %h actual %h", i, e[32*i +: 32],
							out_data[32*i +: 32]);
						errors++;
					end
			end
		end
	end

	function automatic logic [15:0] random_scale();
		case ($urandom_range(5))
			0: return {1'($urandom_range(1)), 5'd0, 10'($urandom)};
			1: return {1'($urandom_range(1)), 5'h1F,
				($urandom_range(1) ? 10'($urandom) : 10'd0)};
			2: return {1'($urandom_range(1)), 15'd0};
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic [15:0] sc [12] = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h0200,
			16'h3C00, 16'hBC00, 16'h7BFF, 16'h7C00, 16'hFC00, 16'h7C01, 16'hFE00};
		foreach (sc[k])
			send_request(32'hFEDC_BA98 ^ (k[0] ? 32'hFFFF_FFFF : 32'h0), sc[k]);
		send_request(32'h7654_3210, 16'h0400);
		send_request(32'h8888_8888, 16'h7C00);
		send_request(32'hFFFF_FFFF, 16'h7BFF);
		send_request(32'h0000_0000, 16'hFBFF);
		send_request(32'h8888_8888, 16'hFC00);
		drain();
	endtask

	task automatic test_random(input int n, input int s_idle, input int r_stall);
		send_idle  = s_idle;
		recv_stall = r_stall;
		repeat (n) send_request($urandom, random_scale());
		drain();
	endtask

	task automatic test_back_pressure();
		send_idle  = 0;
		recv_stall = 0;
		hold_off   = 40;
		repeat (20) send_request($urandom, random_scale());
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(300, 0, 0);
		test_random(300, 69, 0);
		test_random(300, 0, 69);
		test_random(300, 20, 20);
		test_back_pressure();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
rtl/i4gd_pkg.sv
rtl/i4gd_lane.sv
rtl/int4_group_dequantizer_unit.sv
verif/testbench.sv
